// ===== src/msu_pkg.sv =====
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types for the merge sorter unit and its cell chain.
// ----------------------------------------------------------------------------
package msu_pkg;

    // per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic ins;      // insert new key in order
        logic shf;      // shift chain toward cell 0
    } cell_ctrl_t;

endpackage

// ===== src/msu_cell.sv =====
// ----------------------------------------------------------------------------
// msu_cell
// One sorting cell: holds a key, takes the new key or its left neighbor's key
// on insert, and takes its right neighbor's key on shift.
// ----------------------------------------------------------------------------
module msu_cell
    import msu_pkg::*;
#(
    parameter int KEY_WIDTH = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  logic signed [KEY_WIDTH-1:0] new_key,
    input  logic                        left_gt,
    input  logic signed [KEY_WIDTH-1:0] left_key,
    input  logic                        left_valid,
    input  logic signed [KEY_WIDTH-1:0] right_key,
    input  logic                        right_valid,
    output logic signed [KEY_WIDTH-1:0] key,
    output logic                        valid,
    output logic                        gt
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic                        valid_reg;
    logic                        valid_next;

    // empty cell counts as larger than any key; equal keys stay ahead
    assign gt = !valid_reg || (key_reg > new_key);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.ins && gt)
        begin
            if (left_gt)
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
            else
            begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shf)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

// ===== src/merge_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// merge_sorter_unit
// Collects signed keys until a word marked last, then streams them out in
// ascending order; a sticky flag reports keys dropped for lack of room.
// ----------------------------------------------------------------------------
// channel   dir  tdata         tlast      tuser
// s_axis    in   key_in        final_in   -
// m_axis    out  key_out       final_out  dropped
//
// Keys are kept sorted on arrival by a chain of CAPACITY cells: each input word
// is placed in order by the broadcast compare; cell 0 drives m_axis_tdata.
// After the last word, one output word per cycle while m_axis_tready is high.
// s_axis_tready is low while a set is being emitted.
// Reset empties the chain and clears the drop flag; no clearing pass.
// ----------------------------------------------------------------------------
module merge_sorter_unit
    import msu_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((KEY_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // key_in
    input  logic                              s_axis_tlast,   // final_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((KEY_WIDTH+7)/8)*8-1:0]    m_axis_tdata,   // key_out
    output logic                              m_axis_tlast,   // final_out
    output logic                              m_axis_tuser    // dropped
);

    localparam int DATA_W = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic                        in_acc;
    logic                        out_acc;
    logic                        full;
    cell_ctrl_t                  ctrl;
    logic signed [KEY_WIDTH-1:0] new_key;

    logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    logic                        cell_valid [CAPACITY];
    logic                        cell_gt    [CAPACITY];

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign full          = (count_reg == CNT_W'(CAPACITY));
    assign new_key       = s_axis_tdata[KEY_WIDTH-1:0];

    assign ctrl.ins = in_acc && !full;
    assign ctrl.shf = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                        l_gt;
            logic signed [KEY_WIDTH-1:0] l_key;
            logic                        l_valid;
            logic signed [KEY_WIDTH-1:0] r_key;
            logic                        r_valid;

            if (gi == 0)
            begin : g_first
                assign l_gt    = 1'b0;
                assign l_key   = '0;
                assign l_valid = 1'b0;
            end
            else
            begin : g_mid
                assign l_gt    = cell_gt[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_key   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_key   = cell_key[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            msu_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_key     (new_key),
                .left_gt     (l_gt),
                .left_key    (l_key),
                .left_valid  (l_valid),
                .right_key   (r_key),
                .right_valid (r_valid),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CNT_W'(1);
                    if (s_axis_tlast)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_axis_tdata = DATA_W'($unsigned(cell_key[0]));
    assign m_axis_tlast = (count_reg == CNT_W'(1));
    assign m_axis_tuser = ovf_reg;

endmodule

// ===== tb/sv/tb_merge_sorter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_merge_sorter_unit
// Sends sets of signed keys, each closed by a word with tlast, and checks that
// every set comes back in ascending order with tlast on its final key and the
// drop flag set when the set went past the capacity. A sorted shadow copy of
// the current set predicts the output; a short table of directed words comes
// first, then random sets, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_merge_sorter_unit;

    localparam int CAPACITY    = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int TARGET_KEYS = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 200;
    localparam int MAX_IDLE    = 16;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 fin;
        logic                 drop;
    } sorted_word_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 last;
        logic                 typed;      // single-key set, result given below
        logic [KEY_WIDTH-1:0] exp_key;
        logic                 exp_drop;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [KEY_WIDTH-1:0] s_axis_tdata;   // key_in
    logic                 s_axis_tlast;   // final_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [KEY_WIDTH-1:0] m_axis_tdata;   // key_out
    logic                 m_axis_tlast;   // final_out
    logic                 m_axis_tuser;   // dropped

    // travels with the word on s_axis
    logic                 row_typed;
    logic [KEY_WIDTH-1:0] row_exp_key;
    logic                 row_exp_drop;

    logic signed [KEY_WIDTH-1:0] held_keys [CAPACITY];
    int                          held_count;
    bit                          keys_dropped;
    sorted_word_t                sorted_expect [$];

    int           mismatch_count;
    int           cycle_count;
    int           rx_hold;
    int           rx_hold_next;
    bit           rx_calm;
    sorted_word_t got_word;
    sorted_word_t exp_word;

    stim_row_t    dir_rows [22];
    int           keys_sent;
    int           set_no;
    int           set_len;
    bit           tx_calm;

    merge_sorter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // keeps the current set sorted; on the final word releases it as expected output
    task automatic absorb_key(input logic [KEY_WIDTH-1:0] key, input logic last,
                              input logic typed, input logic [KEY_WIDTH-1:0] t_key,
                              input logic t_drop);
        int           pos;
        sorted_word_t w;
        if (held_count < CAPACITY)
        begin
            pos = held_count;
            while (pos > 0 && held_keys[pos-1] > $signed(key))
            begin
                held_keys[pos] = held_keys[pos-1];
                pos--;
            end
            held_keys[pos] = key;
            held_count++;
        end
        else
        begin
            keys_dropped = 1'b1;
        end
        if (last)
        begin
            if (typed)
            begin
                w.key  = t_key;
                w.fin  = 1'b1;
                w.drop = t_drop;
                sorted_expect.push_back(w);
            end
            else
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    w.key  = held_keys[i];
                    w.fin  = (i == held_count - 1);
                    w.drop = keys_dropped;
                    sorted_expect.push_back(w);
                end
            end
            held_count   = 0;
            keys_dropped = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_key(s_axis_tdata, s_axis_tlast, row_typed, row_exp_key, row_exp_drop);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_word.key  = m_axis_tdata;
                got_word.fin  = m_axis_tlast;
                got_word.drop = m_axis_tuser;
                if (sorted_expect.size() == 0)
                begin
                    $display("%0t: unexpected word key=%h last=%b dropped=%b", $time,
                             got_word.key, got_word.fin, got_word.drop);
                    mismatch_count++;
                end
                else
                begin
                    exp_word = sorted_expect.pop_front();
                    if (got_word.key !== exp_word.key)
                    begin
                        $display("%0t: key expected %h actual %h", $time,
                                 exp_word.key, got_word.key);
                        mismatch_count++;
                    end
                    if (got_word.fin !== exp_word.fin)
                    begin
                        $display("%0t: tlast expected %b actual %b", $time,
                                 exp_word.fin, got_word.fin);
                        mismatch_count++;
                    end
                    if (got_word.drop !== exp_word.drop)
                    begin
                        $display("%0t: dropped expected %b actual %b", $time,
                                 exp_word.drop, got_word.drop);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // output backpressure, with calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
            rx_calm       <= 1'b0;
        end
        else
        begin
            rx_hold_next = rx_hold;
            if (m_axis_tvalid && m_axis_tready)
            begin
                rx_hold_next = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
                if ($urandom_range(0, 31) == 0)
                    rx_calm <= ~rx_calm;
            end
            if (rx_hold_next > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold       <= rx_hold_next - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_hold       <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [KEY_WIDTH-1:0] key, input logic last,
                             input logic typed, input logic [KEY_WIDTH-1:0] t_key,
                             input logic t_drop);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= last;
        row_typed     <= typed;
        row_exp_key   <= t_key;
        row_exp_drop  <= t_drop;
        do
            @(posedge clk);
        while (!s_axis_tready);
        keys_sent++;
    endtask

    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sorted_expect.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_WIDTH-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1:       return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        row_typed      = 1'b0;
        row_exp_key    = '0;
        row_exp_drop   = 1'b0;
        held_count     = 0;
        keys_dropped   = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        keys_sent      = 0;
        tx_calm        = 1'b0;

        dir_rows = '{
            // single-key sets at the extremes
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
            // mixed signs, duplicates
            '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0},
            '{32'hFFFF_FFFD, 1'b0, 1'b0, '0, 1'b0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
            '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0},
            // already in order
            '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0002, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0003, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0004, 1'b1, 1'b0, '0, 1'b0},
            // reversed, then a two-key set of opposite signs and a pair of equal keys
            '{32'h0000_0004, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0003, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0002, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0001, 1'b1, 1'b0, '0, 1'b0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0},
            '{32'h5555_5555, 1'b1, 1'b0, '0, 1'b0},
            '{32'h0000_0009, 1'b0, 1'b0, '0, 1'b0},
            '{32'h0000_0009, 1'b1, 1'b0, '0, 1'b0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].key, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].exp_key, dir_rows[i].exp_drop);
        wait_for_results();

        // full, one over (last key lost) and well over capacity come first
        set_no = 0;
        while (keys_sent < TARGET_KEYS)
        begin
            case (set_no)
                0:       set_len = CAPACITY;
                1:       set_len = CAPACITY + 1;
                2:       set_len = CAPACITY + 6;
                default: set_len = ($urandom_range(0, 19) == 0)
                                   ? $urandom_range(CAPACITY - 4, CAPACITY + 8)
                                   : $urandom_range(1, 12);
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++)
                send_word(random_key(), k == set_len - 1, 1'b0, '0, 1'b0);
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
            set_no++;
        end

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && sorted_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
